### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, the substitution table and the GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;

    function automatic t_byte sbox(input t_byte a);
        t_byte r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of a block sits in bits 127-8n down to 120-8n.
    function automatic t_byte get_byte(input t_block b, input int n);
        return b[127 - 8*n -: 8];
    endfunction

    function automatic t_block next_key(input t_block k, input t_byte rcon);
        t_byte rk [16];
        t_block r;
        for (int n = 0; n < 16; n++) rk[n] = get_byte(k, n);
        rk[0] = rk[0] ^ sbox(rk[13]) ^ rcon;
        rk[1] = rk[1] ^ sbox(rk[14]);
        rk[2] = rk[2] ^ sbox(rk[15]);
        rk[3] = rk[3] ^ sbox(rk[12]);
        for (int n = 4; n < 16; n++) rk[n] = rk[n] ^ rk[n-4];
        for (int n = 0; n < 16; n++) r[127 - 8*n -: 8] = rk[n];
        return r;
    endfunction

endpackage

### rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round together with the matching key expansion step.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; #(
    parameter logic [7:0] RCON  = 8'h01,
    parameter bit         FINAL = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_block i_state,
    input  t_block i_key,
    output logic   o_valid,
    output t_block o_state,
    output t_block o_key
);

    t_block n_state, n_key, w_rk;
    logic   r_valid;
    t_block r_state, r_key;

    always_comb begin
        t_byte s [16];
        t_byte t [16];
        t_byte all;
        w_rk = next_key(i_key, RCON);
        for (int n = 0; n < 16; n++) s[n] = get_byte(i_state, n);
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
            end
        end
        if (!FINAL) begin
            for (int c = 0; c < 4; c++) begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                s[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
                s[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
                s[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
                s[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int n = 0; n < 16; n++) s[n] = t[n];
        end
        for (int n = 0; n < 16; n++) n_state[127 - 8*n -: 8] = s[n] ^ get_byte(w_rk, n);
        n_key = w_rk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

### rtl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Fully unrolled pipeline of eleven register stages, one block per cycle unless it holds.
// ----------------------------------------------------------------------------
// Words enter on i_valid/o_stall with the plaintext on i_block_hi/lo and leave
// on o_valid/i_stall with the ciphertext on o_cipher_hi/lo, byte 0 on top.
// The key is written through i_cfg_valid/o_cfg_ready: index 0 is the upper
// key half and index 1 the lower; other indexes are ignored. Write the key
// only while the pipeline is empty.
// The first stage registers the initial key addition and each of the ten
// rounds has its own register stage; one word is accepted every cycle
// unless the pipeline holds. The whole pipeline advances together; while
// the receiver stalls an output word, the pipeline holds only if its last
// stage is full; an empty last stage does not hold it. No word is lost
// or repeated. Reset clears all valid bits and sets the key to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_cipher_hi,
    output logic [63:0] o_cipher_lo,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic CfgKeyHi = 1'b0;
    localparam logic CfgKeyLo = 1'b1;

    logic [63:0] r_key_hi, r_key_lo;
    logic        w_en;
    logic        v [NumRounds+1];
    t_block      st [NumRounds+1];
    t_block      ky [NumRounds+1];
    logic        r_v0;
    t_block      r_s0, r_k0;

    assign o_cfg_ready = 1'b1;
    assign w_en    = !(v[NumRounds] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_v0     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CfgKeyHi: r_key_hi <= i_cfg_data;
                    CfgKeyLo: r_key_lo <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_en) r_v0 <= i_valid;
        end
        if (w_en) begin
            r_s0 <= {i_block_hi, i_block_lo} ^ {r_key_hi, r_key_lo};
            r_k0 <= {r_key_hi, r_key_lo};
        end
    end

    assign v[0]  = r_v0;
    assign st[0] = r_s0;
    assign ky[0] = r_k0;

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        localparam logic [7:0] Rc = (g < 8) ? 8'(1 << g) : ((g == 8) ? 8'h1b : 8'h36);
        aes_round #(.RCON(Rc), .FINAL(g == NumRounds - 1)) u_round (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(v[g]), .i_state(st[g]), .i_key(ky[g]),
            .o_valid(v[g+1]), .o_state(st[g+1]), .o_key(ky[g+1])
        );
    end

    assign o_valid     = v[NumRounds];
    assign o_cipher_hi = st[NumRounds][127:64];
    assign o_cipher_lo = st[NumRounds][63:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cipher_hi) && $stable(o_cipher_lo))
        else $error("output word changed while stalled");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a full stalled output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !v[NumRounds-1] |=> !o_valid)
        else $error("output word appeared from an empty stage");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Drives plaintext words and key writes into the encryption pipeline, predicts
// every ciphertext word with an independent software cipher and compares the
// words that leave the block in order. Both sides idle at random, the receiver
// holds off once for a long stretch, and the key goes through several values.
// ----------------------------------------------------------------------------
module tb_top;
    import aes_pkg::*;

    localparam logic KEY_HI_IDX = 1'b0;
    localparam logic KEY_LO_IDX = 1'b1;
    localparam int   IDLE_LIMIT = 5000;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN_CYCLES = 20;

    class cipher_scoreboard;
        static const logic [7:0] SUB [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
            8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
            8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
            8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
            8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
            8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
            8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
            8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
            8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
            8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
            8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
            8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
            8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
            8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
            8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
            8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
            8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };

        logic [127:0] cipher_q[$];
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        int           errors;

        function new();
            key_hi = '0;
            key_lo = '0;
            errors = 0;
        endfunction

        static function logic [7:0] dbl(logic [7:0] v);
            return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
        endfunction

        static function logic [127:0] encrypt(logic [127:0] key, logic [127:0] pt);
            logic [7:0] st [16];
            logic [7:0] rk [16];
            logic [7:0] t  [16];
            logic [7:0] rcon;
            logic [7:0] all;
            logic [127:0] ct;
            for (int n = 0; n < 16; n++) begin
                st[n] = pt[127 - 8*n -: 8] ^ key[127 - 8*n -: 8];
                rk[n] = key[127 - 8*n -: 8];
            end
            rcon = 8'h01;
            for (int rnd = 1; rnd <= 10; rnd++) begin
                t[0] = rk[0] ^ SUB[rk[13]] ^ rcon;
                t[1] = rk[1] ^ SUB[rk[14]];
                t[2] = rk[2] ^ SUB[rk[15]];
                t[3] = rk[3] ^ SUB[rk[12]];
                for (int n = 0; n < 4; n++) rk[n] = t[n];
                for (int n = 4; n < 16; n++) rk[n] = rk[n] ^ rk[n-4];
                rcon = dbl(rcon);
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*c + r] = SUB[st[4*((c + r) % 4) + r]];
                if (rnd < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                        st[4*c]   = t[4*c]   ^ all ^ dbl(t[4*c]   ^ t[4*c+1]);
                        st[4*c+1] = t[4*c+1] ^ all ^ dbl(t[4*c+1] ^ t[4*c+2]);
                        st[4*c+2] = t[4*c+2] ^ all ^ dbl(t[4*c+2] ^ t[4*c+3]);
                        st[4*c+3] = t[4*c+3] ^ all ^ dbl(t[4*c+3] ^ t[4*c]);
                    end
                end else begin
                    for (int n = 0; n < 16; n++) st[n] = t[n];
                end
                for (int n = 0; n < 16; n++) st[n] = st[n] ^ rk[n];
            end
            for (int n = 0; n < 16; n++) ct[127 - 8*n -: 8] = st[n];
            return ct;
        endfunction

        function void write_key(logic idx, logic [63:0] data);
            if (idx == KEY_HI_IDX) key_hi = data;
            else key_lo = data;
        endfunction

        function void note_block(logic [63:0] hi, logic [63:0] lo);
            cipher_q.push_back(encrypt({key_hi, key_lo}, {hi, lo}));
        endfunction

        function void check_word(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] exp_ct;
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected word hi=%h lo=%h", $time, hi, lo);
                errors++;
                return;
            end
            exp_ct = cipher_q.pop_front();
            if (hi !== exp_ct[127:64]) begin
                $display("%0t: cipher_hi expected %h actual %h", $time, exp_ct[127:64], hi);
                errors++;
            end
            if (lo !== exp_ct[63:0]) begin
                $display("%0t: cipher_lo expected %h actual %h", $time, exp_ct[63:0], lo);
                errors++;
            end
        endfunction

        function int pending();
            return cipher_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_block_hi;
    logic [63:0] i_block_lo;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_cipher_hi;
    logic [63:0] o_cipher_lo;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    cipher_scoreboard sb = new();
    bit quiet = 0;
    int hold_ask = 0;
    int idle_cnt = 0;

    aes128_block_encrypt i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_block_hi(i_block_hi), .i_block_lo(i_block_lo),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cipher_hi(o_cipher_hi), .o_cipher_lo(o_cipher_lo),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_word(o_cipher_hi, o_cipher_lo);
    end

    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ask > 0) begin
                hold_left = hold_ask;
                hold_ask = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_half();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_cfg(logic idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_key(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        while (!quiet && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_block_hi <= hi;
        i_block_lo <= lo;
        do @(posedge i_clk); while (o_stall);
        sb.note_block(hi, lo);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic new_key(logic [63:0] hi, logic [63:0] lo);
        drain();
        write_cfg(KEY_HI_IDX, hi);
        write_cfg(KEY_LO_IDX, lo);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_block_hi  = '0;
        i_block_lo  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = KEY_HI_IDX;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the unwritten key first, then standard and extreme keys.
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        new_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_block('0, '1);
        new_key(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
        send_block(64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734);
        new_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        new_key('0, '1);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        // Key change with the pipeline full of the old key is not allowed, so
        // a change between back-to-back words is covered by a drained swap.
        new_key('1, '0);
        send_block('1, '0);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 0) new_key('0, '0);
            else if (ph == 1) new_key('1, '1);
            else new_key(rand_half(), rand_half());
            quiet = (ph == 3);
            if (ph == 5) hold_ask = HOLD_CYCLES;
            for (int k = 0; k < 200; k++) send_block(rand_half(), rand_half());
            quiet = 0;
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

### aes128_block_encrypt.f
rtl/aes_pkg.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt.sv
verif/tb_top.sv
